### sv/mbrtu_pkg.sv
// ----------------------------------------------------------------------------
// mbrtu_pkg: shared types and constants of the Modbus RTU master
// Command, result and status codes, sequencer states and the CRC-16 byte step.
// ----------------------------------------------------------------------------
package mbrtu_pkg;

    // Input commands carried in tuser.
    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_BYTE  = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;

    // Result kinds carried in tuser.
    localparam logic [1:0] KIND_TX   = 2'd0;
    localparam logic [1:0] KIND_WORD = 2'd1;
    localparam logic [1:0] KIND_DONE = 2'd2;

    // Completion status codes.
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_CRC    = 2'd1;
    localparam logic [1:0] ST_NORESP = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_SILENCE  = 2'd0;
    localparam logic [1:0] CFG_RESPONSE = 2'd1;
    localparam logic [1:0] CFG_RETRIES  = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [15:0] SILENCE_RESET  = 16'd2;
    localparam logic [15:0] RESPONSE_RESET = 16'd1500;
    localparam logic [3:0]  RETRIES_RESET  = 4'd5;

    // Most data words returned for one frame.
    localparam logic [4:0] MAX_WORDS = 5'd31;

    // Transaction phase.
    typedef enum logic [1:0] {
        PH_IDLE,
        PH_WAIT,
        PH_RECV
    } phase_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_READY,
        S_REQ_CRC,
        S_REQ_TX,
        S_FE_START,
        S_FE_FC,
        S_FE_BC,
        S_FE_CRC,
        S_FE_WLO,
        S_FE_WHI,
        S_FE_ONE,
        S_W_HI,
        S_W_LO,
        S_ZERO,
        S_DONE
    } state_t;

    // One byte through CRC-16/MODBUS (reflected polynomial 0xA001).
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int b = 0; b < 8; b++) begin
            c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
        end
        return c;
    endfunction

endpackage

### sv/modbus_rtu_master_transaction.sv
// ----------------------------------------------------------------------------
// modbus_rtu_master_transaction: Modbus RTU master, one request at a time
// Builds and sends request frames, times responses, buffers received bytes
// and checks and decodes a frame once the line has gone silent.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake                      Contents
//  s_axis   in         s_axis_tvalid / s_axis_tready  command, request, rx byte
//  m_axis   out        m_axis_tvalid / m_axis_tready  tx byte, data word, done
//  cfg      in         cfg_we                         timer and retry registers
//
//  A request runs six header bytes through the shared byte-wide CRC unit,
//  then sends eight bytes as output slots free. A frame check reads the
//  receive buffer one byte a cycle through its single read port while no
//  stall holds it. The input is not ready until the item's last word is in
//  the output register; a stalled output holds the sequencer. Reset is
//  asynchronous.
// ----------------------------------------------------------------------------
module modbus_rtu_master_transaction #(
    parameter int RX_BUFFER_DEPTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] func_code, [15:8] slave_addr, [31:16] start_addr,
    // [47:32] quantity, [55:48] rx_byte
    input  logic [55:0] s_axis_tdata,
    // [1:0] cmd
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] tx_byte, [23:8] reg_value, [25:24] status, [31:26] zero
    output logic [31:0] m_axis_tdata,
    // [1:0] out_kind
    output logic [1:0]  m_axis_tuser,
    output logic        m_axis_tlast,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int AW = $clog2(RX_BUFFER_DEPTH);
    localparam int CW = $clog2(RX_BUFFER_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(RX_BUFFER_DEPTH);

    // Configuration registers.
    logic [15:0] silence_ticks_reg, response_ticks_reg;
    logic [3:0]  max_retries_reg;

    // Sequencer and transaction state.
    mbrtu_pkg::state_t state_reg, state_next;
    mbrtu_pkg::phase_t phase_reg, phase_next;
    logic [CW-1:0] rx_count_reg, rx_count_next;
    logic [15:0]   sil_timer_reg, sil_timer_next;
    logic          sil_armed_reg, sil_armed_next;
    logic [15:0]   resp_timer_reg, resp_timer_next;
    logic          resp_armed_reg, resp_armed_next;
    logic [3:0]    retry_reg, retry_next;
    logic [7:0]    s_func_reg, s_func_next;
    logic [7:0]    s_slave_reg, s_slave_next;
    logic [15:0]   s_addr_reg, s_addr_next;
    logic [15:0]   s_qty_reg, s_qty_next;

    // Working registers of the shared unit.
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  cnt_reg, cnt_next;
    logic [7:0]  bc_reg, bc_next;
    logic [4:0]  nw_reg, nw_next;
    logic [7:0]  fc_reg, fc_next;
    logic [7:0]  want_lo_reg, want_lo_next;
    logic [7:0]  hi_reg, hi_next;
    logic [1:0]  status_reg, status_next;

    // Output register.
    logic        m_valid_reg, m_valid_next;
    logic [1:0]  o_kind_reg, o_kind_next;
    logic [7:0]  o_tx_reg, o_tx_next;
    logic [15:0] o_val_reg, o_val_next;
    logic [1:0]  o_st_reg, o_st_next;
    logic        o_last_reg, o_last_next;

    // Receive buffer.
    logic [7:0]    rx_mem [RX_BUFFER_DEPTH];
    logic [7:0]    rd_data_reg;
    logic [AW-1:0] rd_addr;
    logic [8:0]    addr_full;
    logic          mem_we;

    // Combinational helpers.
    logic        accept;
    logic        slot_free;
    logic [1:0]  cmd;
    logic [7:0]  req_byte;
    logic [7:0]  tx_sel;
    logic [8:0]  bc_plus5;
    logic [8:0]  bc_half;
    logic [15:0] crc_step;
    logic [8:0]  cnt_ext;

    assign s_axis_tready = (state_reg == mbrtu_pkg::S_READY);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign cmd           = s_axis_tuser;
    assign slot_free     = !m_valid_reg || m_axis_tready;
    assign cnt_ext       = {1'b0, cnt_reg};
    assign bc_plus5      = {1'b0, bc_reg} + 9'd5;
    assign bc_half       = ({1'b0, rd_data_reg} + 9'd1) >> 1;

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = o_kind_reg;
    assign m_axis_tlast  = o_last_reg;
    assign m_axis_tdata  = {6'd0, o_st_reg, o_val_reg, o_tx_reg};

    // Request frame byte for the sequence index.
    always_comb begin
        case (cnt_reg[2:0])
            3'd0:    req_byte = s_slave_reg;
            3'd1:    req_byte = s_func_reg;
            3'd2:    req_byte = s_addr_reg[15:8];
            3'd3:    req_byte = s_addr_reg[7:0];
            3'd4:    req_byte = s_qty_reg[15:8];
            3'd5:    req_byte = s_qty_reg[7:0];
            3'd6:    req_byte = crc_reg[7:0];
            default: req_byte = crc_reg[15:8];
        endcase
    end

    // The shared CRC unit takes a request byte or a buffered byte.
    assign tx_sel   = (state_reg == mbrtu_pkg::S_REQ_CRC) ? req_byte : rd_data_reg;
    assign crc_step = mbrtu_pkg::crc16_byte(crc_reg, tx_sel);

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            silence_ticks_reg  <= mbrtu_pkg::SILENCE_RESET;
            response_ticks_reg <= mbrtu_pkg::RESPONSE_RESET;
            max_retries_reg    <= mbrtu_pkg::RETRIES_RESET;
        end
        else if (cfg_we) begin
            unique case (cfg_index)
                mbrtu_pkg::CFG_SILENCE:  silence_ticks_reg  <= cfg_data;
                mbrtu_pkg::CFG_RESPONSE: response_ticks_reg <= cfg_data;
                mbrtu_pkg::CFG_RETRIES:  max_retries_reg    <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // Receive buffer: one write port, one registered read port.
    assign mem_we = accept && (cmd == mbrtu_pkg::CMD_BYTE) &&
                    (phase_reg != mbrtu_pkg::PH_IDLE) && (rx_count_reg < DEPTH_C);

    always_ff @(posedge clk) begin
        if (mem_we) begin
            rx_mem[rx_count_reg[AW-1:0]] <= s_axis_tdata[55:48];
        end
        rd_data_reg <= rx_mem[rd_addr];
    end

    assign rd_addr = addr_full[AW-1:0];

    // Sequencer state and working registers.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg      <= mbrtu_pkg::S_READY;
            phase_reg      <= mbrtu_pkg::PH_IDLE;
            rx_count_reg   <= '0;
            sil_timer_reg  <= '0;
            sil_armed_reg  <= 1'b0;
            resp_timer_reg <= '0;
            resp_armed_reg <= 1'b0;
            retry_reg      <= '0;
            s_func_reg     <= '0;
            s_slave_reg    <= '0;
            s_addr_reg     <= '0;
            s_qty_reg      <= '0;
            m_valid_reg    <= 1'b0;
        end
        else begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            rx_count_reg   <= rx_count_next;
            sil_timer_reg  <= sil_timer_next;
            sil_armed_reg  <= sil_armed_next;
            resp_timer_reg <= resp_timer_next;
            resp_armed_reg <= resp_armed_next;
            retry_reg      <= retry_next;
            s_func_reg     <= s_func_next;
            s_slave_reg    <= s_slave_next;
            s_addr_reg     <= s_addr_next;
            s_qty_reg      <= s_qty_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk) begin
        crc_reg     <= crc_next;
        cnt_reg     <= cnt_next;
        bc_reg      <= bc_next;
        nw_reg      <= nw_next;
        fc_reg      <= fc_next;
        want_lo_reg <= want_lo_next;
        hi_reg      <= hi_next;
        status_reg  <= status_next;
        o_kind_reg  <= o_kind_next;
        o_tx_reg    <= o_tx_next;
        o_val_reg   <= o_val_next;
        o_st_reg    <= o_st_next;
        o_last_reg  <= o_last_next;
    end

    // Next state and outputs.
    always_comb begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        rx_count_next   = rx_count_reg;
        sil_timer_next  = sil_timer_reg;
        sil_armed_next  = sil_armed_reg;
        resp_timer_next = resp_timer_reg;
        resp_armed_next = resp_armed_reg;
        retry_next      = retry_reg;
        s_func_next     = s_func_reg;
        s_slave_next    = s_slave_reg;
        s_addr_next     = s_addr_reg;
        s_qty_next      = s_qty_reg;
        crc_next        = crc_reg;
        cnt_next        = cnt_reg;
        bc_next         = bc_reg;
        nw_next         = nw_reg;
        fc_next         = fc_reg;
        want_lo_next    = want_lo_reg;
        hi_next         = hi_reg;
        status_next     = status_reg;
        addr_full       = cnt_ext;
        m_valid_next    = m_valid_reg && !m_axis_tready;
        o_kind_next     = o_kind_reg;
        o_tx_next       = o_tx_reg;
        o_val_next      = o_val_reg;
        o_st_next       = o_st_reg;
        o_last_next     = o_last_reg;

        unique case (state_reg)
            mbrtu_pkg::S_READY: begin
                if (accept) begin
                    unique case (cmd)
                        mbrtu_pkg::CMD_START: begin
                            s_func_next     = s_axis_tdata[7:0];
                            s_slave_next    = s_axis_tdata[15:8];
                            s_addr_next     = s_axis_tdata[31:16];
                            s_qty_next      = s_axis_tdata[47:32];
                            retry_next      = '0;
                            rx_count_next   = '0;
                            sil_armed_next  = 1'b0;
                            sil_timer_next  = '0;
                            resp_timer_next = response_ticks_reg;
                            resp_armed_next = 1'b1;
                            phase_next      = mbrtu_pkg::PH_WAIT;
                            crc_next        = 16'hFFFF;
                            cnt_next        = '0;
                            state_next      = mbrtu_pkg::S_REQ_CRC;
                        end
                        mbrtu_pkg::CMD_BYTE: begin
                            if (phase_reg != mbrtu_pkg::PH_IDLE) begin
                                if (rx_count_reg < DEPTH_C) begin
                                    rx_count_next = rx_count_reg + 1'b1;
                                end
                                sil_timer_next  = silence_ticks_reg;
                                sil_armed_next  = 1'b1;
                                resp_armed_next = 1'b0;
                                phase_next      = mbrtu_pkg::PH_RECV;
                            end
                        end
                        mbrtu_pkg::CMD_TICK: begin
                            if (phase_reg != mbrtu_pkg::PH_IDLE && sil_armed_reg) begin
                                if (sil_timer_reg == '0) begin
                                    // Silence expired: the frame is complete.
                                    sil_armed_next  = 1'b0;
                                    sil_timer_next  = '0;
                                    resp_armed_next = 1'b0;
                                    retry_next      = '0;
                                    state_next      = mbrtu_pkg::S_FE_START;
                                end
                                else begin
                                    sil_timer_next = sil_timer_reg - 16'd1;
                                end
                            end
                            else if (phase_reg != mbrtu_pkg::PH_IDLE && resp_armed_reg) begin
                                if (resp_timer_reg <= 16'd1) begin
                                    resp_timer_next = '0;
                                    resp_armed_next = 1'b0;
                                    if (retry_reg < max_retries_reg) begin
                                        retry_next      = retry_reg + 4'd1;
                                        rx_count_next   = '0;
                                        sil_armed_next  = 1'b0;
                                        sil_timer_next  = '0;
                                        resp_timer_next = response_ticks_reg;
                                        resp_armed_next = 1'b1;
                                        phase_next      = mbrtu_pkg::PH_WAIT;
                                        crc_next        = 16'hFFFF;
                                        cnt_next        = '0;
                                        state_next      = mbrtu_pkg::S_REQ_CRC;
                                    end
                                    else begin
                                        retry_next  = '0;
                                        status_next = mbrtu_pkg::ST_NORESP;
                                        state_next  = mbrtu_pkg::S_DONE;
                                    end
                                end
                                else begin
                                    resp_timer_next = resp_timer_reg - 16'd1;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end

            // Request CRC over the six header bytes, one byte a cycle.
            mbrtu_pkg::S_REQ_CRC: begin
                crc_next = crc_step;
                if (cnt_reg == 8'd5) begin
                    cnt_next   = '0;
                    state_next = mbrtu_pkg::S_REQ_TX;
                end
                else begin
                    cnt_next = cnt_reg + 8'd1;
                end
            end

            // Send the eight request bytes.
            mbrtu_pkg::S_REQ_TX: begin
                if (slot_free) begin
                    m_valid_next = 1'b1;
                    o_kind_next  = mbrtu_pkg::KIND_TX;
                    o_tx_next    = req_byte;
                    o_val_next   = '0;
                    o_st_next    = mbrtu_pkg::ST_OK;
                    o_last_next  = (cnt_reg == 8'd7);
                    cnt_next     = cnt_reg + 8'd1;
                    if (cnt_reg == 8'd7) begin
                        state_next = mbrtu_pkg::S_READY;
                    end
                end
            end

            // Frame check: fetch the function code.
            mbrtu_pkg::S_FE_START: begin
                addr_full = 9'd1;
                if (rx_count_reg >= CW'(2)) begin
                    state_next = mbrtu_pkg::S_FE_FC;
                end
                else begin
                    status_next = mbrtu_pkg::ST_CRC;
                    state_next  = mbrtu_pkg::S_DONE;
                end
            end

            mbrtu_pkg::S_FE_FC: begin
                addr_full = 9'd2;
                fc_next   = rd_data_reg;
                if (rd_data_reg < 8'd1 || rd_data_reg > 8'd6) begin
                    // Unknown function: send the request again.
                    rx_count_next   = '0;
                    sil_armed_next  = 1'b0;
                    sil_timer_next  = '0;
                    resp_timer_next = response_ticks_reg;
                    resp_armed_next = 1'b1;
                    phase_next      = mbrtu_pkg::PH_WAIT;
                    crc_next        = 16'hFFFF;
                    cnt_next        = '0;
                    state_next      = mbrtu_pkg::S_REQ_CRC;
                end
                else if (rx_count_reg < CW'(3)) begin
                    status_next = mbrtu_pkg::ST_CRC;
                    state_next  = mbrtu_pkg::S_DONE;
                end
                else begin
                    state_next = mbrtu_pkg::S_FE_BC;
                end
            end

            // Byte count: word count and length check.
            mbrtu_pkg::S_FE_BC: begin
                addr_full = 9'd0;
                bc_next   = rd_data_reg;
                nw_next   = (bc_half > 9'(mbrtu_pkg::MAX_WORDS)) ?
                            mbrtu_pkg::MAX_WORDS : bc_half[4:0];
                crc_next  = 16'hFFFF;
                cnt_next  = '0;
                cnt_next  = '0;
                if ({{(10-CW){1'b0}}, rx_count_reg} >= ({1'b0, rd_data_reg} + 10'd5)) begin
                    state_next = mbrtu_pkg::S_FE_CRC;
                end
                else begin
                    state_next = mbrtu_pkg::S_ZERO;
                end
            end

            // Frame CRC over bytes 0 .. bc+2, one byte a cycle.
            mbrtu_pkg::S_FE_CRC: begin
                crc_next  = crc_step;
                addr_full = cnt_ext + 9'd1;
                cnt_next  = cnt_reg + 8'd1;
                if (cnt_ext == ({1'b0, bc_reg} + 9'd2)) begin
                    state_next = mbrtu_pkg::S_FE_WLO;
                end
            end

            mbrtu_pkg::S_FE_WLO: begin
                want_lo_next = rd_data_reg;
                addr_full    = bc_plus5 - 9'd1;
                state_next   = mbrtu_pkg::S_FE_WHI;
            end

            mbrtu_pkg::S_FE_WHI: begin
                addr_full = 9'd3;
                cnt_next  = '0;
                if (crc_reg == {rd_data_reg, want_lo_reg}) begin
                    if (fc_reg == 8'd1 || fc_reg == 8'd2 || fc_reg == 8'd5) begin
                        state_next = mbrtu_pkg::S_FE_ONE;
                    end
                    else if (nw_reg == '0) begin
                        status_next = mbrtu_pkg::ST_OK;
                        state_next  = mbrtu_pkg::S_DONE;
                    end
                    else begin
                        state_next = mbrtu_pkg::S_W_HI;
                    end
                end
                else begin
                    state_next = mbrtu_pkg::S_ZERO;
                end
            end

            // Single data byte for the bit functions.
            mbrtu_pkg::S_FE_ONE: begin
                addr_full = 9'd3;
                if (slot_free) begin
                    m_valid_next = 1'b1;
                    o_kind_next  = mbrtu_pkg::KIND_WORD;
                    o_tx_next    = '0;
                    o_val_next   = {8'd0, rd_data_reg};
                    o_st_next    = mbrtu_pkg::ST_OK;
                    o_last_next  = 1'b0;
                    status_next  = mbrtu_pkg::ST_OK;
                    state_next   = mbrtu_pkg::S_DONE;
                end
            end

            // Register words: high byte, then low byte.
            mbrtu_pkg::S_W_HI: begin
                hi_next    = rd_data_reg;
                addr_full  = {cnt_ext[7:0], 1'b0} + 9'd4;
                state_next = mbrtu_pkg::S_W_LO;
            end

            mbrtu_pkg::S_W_LO: begin
                addr_full = {cnt_ext[7:0], 1'b0} + 9'd4;
                if (slot_free) begin
                    m_valid_next = 1'b1;
                    o_kind_next  = mbrtu_pkg::KIND_WORD;
                    o_tx_next    = '0;
                    o_val_next   = {hi_reg, rd_data_reg};
                    o_st_next    = mbrtu_pkg::ST_OK;
                    o_last_next  = 1'b0;
                    cnt_next     = cnt_reg + 8'd1;
                    addr_full    = {cnt_ext[7:0], 1'b0} + 9'd5;
                    if (cnt_reg == {3'd0, nw_reg - 5'd1}) begin
                        status_next = mbrtu_pkg::ST_OK;
                        state_next  = mbrtu_pkg::S_DONE;
                    end
                    else begin
                        state_next = mbrtu_pkg::S_W_HI;
                    end
                end
            end

            // Failed check: zero words, then the error status.
            mbrtu_pkg::S_ZERO: begin
                if (cnt_reg == {3'd0, nw_reg}) begin
                    status_next = mbrtu_pkg::ST_CRC;
                    state_next  = mbrtu_pkg::S_DONE;
                end
                else if (slot_free) begin
                    m_valid_next = 1'b1;
                    o_kind_next  = mbrtu_pkg::KIND_WORD;
                    o_tx_next    = '0;
                    o_val_next   = '0;
                    o_st_next    = mbrtu_pkg::ST_OK;
                    o_last_next  = 1'b0;
                    cnt_next     = cnt_reg + 8'd1;
                end
            end

            // Done word closes the transaction.
            mbrtu_pkg::S_DONE: begin
                if (slot_free) begin
                    m_valid_next    = 1'b1;
                    o_kind_next     = mbrtu_pkg::KIND_DONE;
                    o_tx_next       = '0;
                    o_val_next      = '0;
                    o_st_next       = status_reg;
                    o_last_next     = 1'b1;
                    phase_next      = mbrtu_pkg::PH_IDLE;
                    resp_armed_next = 1'b0;
                    sil_armed_next  = 1'b0;
                    state_next      = mbrtu_pkg::S_READY;
                end
            end

            default: state_next = mbrtu_pkg::S_READY;
        endcase
    end

endmodule
